### rtl/mevb_pkg.sv
// Shared constants, types and arithmetic helpers for the mouse event buffer.
package mevb_pkg;

    localparam int EVENT_DEPTH   = 64;
    localparam int FRACTION_BITS = 8;
    localparam int MAX_RESULTS   = 64;

    localparam int FUNC_W  = 3;
    localparam int DELTA_W = 24;
    localparam int IDX_W   = 3;
    localparam int DRAIN_W = 7;
    localparam int KIND_W  = 2;
    localparam int CODE_W  = 3;
    localparam int VAL_W   = 32;
    localparam int MASK_W  = 4;
    localparam int ACC_W   = 40;
    localparam int Z_W     = DELTA_W + 8;
    localparam int BSEL_W  = $clog2(MASK_W);

    localparam int PTR_W   = $clog2(EVENT_DEPTH);
    localparam int CNT_W   = $clog2(EVENT_DEPTH + 1);
    localparam int RES_W   = $clog2(MAX_RESULTS + 1);
    localparam int CMP_A   = (CNT_W > DRAIN_W) ? CNT_W : DRAIN_W;
    localparam int CMP_W   = (CMP_A > RES_W) ? CMP_A : RES_W;
    localparam int ENTRY_W = CODE_W + VAL_W;

    localparam logic signed [Z_W-1:0]   WHEEL_UNITS = Z_W'(120);
    localparam logic signed [VAL_W-1:0] PRESS_VALUE = VAL_W'(128);
    localparam logic [IDX_W-1:0]        BTN_LAST    = IDX_W'(MASK_W - 1);

    localparam logic signed [ACC_W:0] FRAC_MASK = (ACC_W + 1)'((1 << FRACTION_BITS) - 1);
    localparam logic signed [ACC_W:0] W_MAX     = (ACC_W + 1)'(2 ** (VAL_W - 1) - 1);
    localparam logic signed [ACC_W:0] W_MIN     = -W_MAX - (ACC_W + 1)'(1);

    typedef enum logic [FUNC_W-1:0] {
        FN_MOTION = 3'd0,
        FN_BUTTON = 3'd1,
        FN_WHEEL  = 3'd2,
        FN_READ   = 3'd3,
        FN_DRAIN  = 3'd4
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_REPORT = 2'd0,
        KIND_EVENT  = 2'd1,
        KIND_EMPTY  = 2'd2
    } kind_t;

    localparam logic [CODE_W-1:0] EV_X     = 3'd0;
    localparam logic [CODE_W-1:0] EV_Y     = 3'd1;
    localparam logic [CODE_W-1:0] EV_WHEEL = 3'd2;
    localparam logic [CODE_W-1:0] EV_BTN0  = 3'd3;

    typedef enum logic [2:0] {
        ACC_NONE   = 3'd0,
        ACC_MOTION = 3'd1,
        ACC_WHEEL  = 3'd2,
        ACC_BUTTON = 3'd3,
        ACC_CALC   = 3'd4,
        ACC_TAKE   = 3'd5
    } acc_op_t;

    typedef struct packed {
        logic [CODE_W-1:0]       code;
        logic signed [VAL_W-1:0] value;
    } ring_entry_t;

    typedef struct packed {
        acc_op_t                   op;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [Z_W-1:0]     z;
        logic [IDX_W-1:0]          bidx;
        logic                      down;
    } acc_cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] rx;
        logic signed [VAL_W-1:0] ry;
        logic signed [VAL_W-1:0] rz;
        logic [MASK_W-1:0]       mask;
    } acc_report_t;

    typedef struct packed {
        logic        push;
        ring_entry_t entry;
        logic        pop_rd;
        logic        pop_adv;
    } ring_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        ring_entry_t      rdata;
    } ring_stat_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [VAL_W-1:0] dx;
        logic signed [VAL_W-1:0] dy;
        logic signed [VAL_W-1:0] dz;
        logic [MASK_W-1:0]       mask;
        logic [CODE_W-1:0]       code;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } rsp_t;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] a);
        logic signed [ACC_W-1:0] r;
        if (a[ACC_W] != a[ACC_W-1])
            r = a[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
        else
            r = a[ACC_W-1:0];
        return r;
    endfunction

    // Whole part, truncated toward zero and saturated to the report width.
    function automatic logic signed [VAL_W-1:0] whole32(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0]   s;
        logic signed [ACC_W:0]   w;
        logic signed [VAL_W-1:0] r;
        s = (ACC_W + 1)'(a) + (a[ACC_W-1] ? FRAC_MASK : '0);
        w = s >>> FRACTION_BITS;
        if (w > W_MAX)
            r = W_MAX[VAL_W-1:0];
        else if (w < W_MIN)
            r = W_MIN[VAL_W-1:0];
        else
            r = w[VAL_W-1:0];
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(p) + (CNT_W + 1)'(n);
        if (s >= (CNT_W + 1)'(EVENT_DEPTH))
            s = s - (CNT_W + 1)'(EVENT_DEPTH);
        return s[PTR_W-1:0];
    endfunction

endpackage

### rtl/mevb_if.sv
// Command and response channel interfaces of the mouse event buffer.
interface mevb_cmd_if;
    import mevb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic signed [DELTA_W-1:0] wheel_steps;
    logic [IDX_W-1:0]          button_index;
    logic                      button_down;
    logic [DRAIN_W-1:0]        drain_max;

    modport source (
        output valid, func, delta_x, delta_y, wheel_steps, button_index, button_down,
               drain_max,
        input  ready
    );

    modport sink (
        input  valid, func, delta_x, delta_y, wheel_steps, button_index, button_down,
               drain_max,
        output ready
    );
endinterface

interface mevb_rsp_if;
    import mevb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       result_kind;
    logic signed [VAL_W-1:0] report_dx;
    logic signed [VAL_W-1:0] report_dy;
    logic signed [VAL_W-1:0] report_dz;
    logic [MASK_W-1:0]       button_mask;
    logic [CODE_W-1:0]       event_code;
    logic signed [VAL_W-1:0] event_value;
    logic                    last;

    modport source (
        output valid, result_kind, report_dx, report_dy, report_dz, button_mask, event_code,
               event_value, last,
        input  ready
    );

    modport sink (
        input  valid, result_kind, report_dx, report_dy, report_dz, button_mask, event_code,
               event_value, last,
        output ready
    );
endinterface

### rtl/mevb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mevb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/mevb_ring.sv
// Event ring: head and count pointers around the ring RAM, oldest dropped when full.
module mevb_ring (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mevb_pkg::ring_cmd_t   cmd,
    output mevb_pkg::ring_stat_t  stat
);
    import mevb_pkg::*;

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] waddr;
    ring_entry_t      rdata;

    assign waddr = ring_add(head_reg, count_reg);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            if (count_reg == CNT_W'(EVENT_DEPTH))
                head_next = ring_add(head_reg, CNT_W'(1));
            else
                count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop_adv)
        begin
            head_next  = ring_add(head_reg, CNT_W'(1));
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    mevb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (EVENT_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (waddr),
        .wdata (cmd.entry),
        .re    (cmd.pop_rd),
        .raddr (head_reg),
        .rdata (rdata)
    );

    assign stat.count = count_reg;
    assign stat.rdata = rdata;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(EVENT_DEPTH))
        else $error("ring count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_adv |-> count_reg != '0)
        else $error("pop from empty ring");

    a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && count_reg == CNT_W'(EVENT_DEPTH)) |=> count_reg == CNT_W'(EVENT_DEPTH))
        else $error("push on full ring changed count");

endmodule

### rtl/mevb_accum.sv
// Motion and wheel accumulators, held button mask and state report computation.
module mevb_accum (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mevb_pkg::acc_cmd_t     cmd,
    output mevb_pkg::acc_report_t  report
);
    import mevb_pkg::*;

    logic signed [ACC_W-1:0] x_reg;
    logic signed [ACC_W-1:0] x_next;
    logic signed [ACC_W-1:0] y_reg;
    logic signed [ACC_W-1:0] y_next;
    logic signed [ACC_W-1:0] z_reg;
    logic signed [ACC_W-1:0] z_next;
    logic [MASK_W-1:0]       held_reg;
    logic [MASK_W-1:0]       held_next;
    logic signed [VAL_W-1:0] rx_reg;
    logic signed [VAL_W-1:0] ry_reg;
    logic signed [VAL_W-1:0] rz_reg;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        held_next = held_reg;
        case (cmd.op)
            ACC_MOTION:
            begin
                x_next = sat_acc((ACC_W + 1)'(x_reg) + (ACC_W + 1)'(cmd.dx));
                y_next = sat_acc((ACC_W + 1)'(y_reg) + (ACC_W + 1)'(cmd.dy));
            end
            ACC_WHEEL:
            begin
                z_next = sat_acc((ACC_W + 1)'(z_reg) + (ACC_W + 1)'(cmd.z));
            end
            ACC_BUTTON:
            begin
                held_next[cmd.bidx[BSEL_W-1:0]] = cmd.down;
            end
            ACC_TAKE:
            begin
                x_next = x_reg - (ACC_W'(rx_reg) <<< FRACTION_BITS);
                y_next = y_reg - (ACC_W'(ry_reg) <<< FRACTION_BITS);
                z_next = z_reg - (ACC_W'(rz_reg) <<< FRACTION_BITS);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            held_reg <= '0;
        end
        else
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            held_reg <= held_next;
        end
    end

    // Hold the whole parts until the report is taken.
    always_ff @(posedge clk)
    begin
        if (cmd.op == ACC_CALC)
        begin
            rx_reg <= whole32(x_reg);
            ry_reg <= whole32(y_reg);
            rz_reg <= whole32(z_reg);
        end
    end

    assign report.rx   = rx_reg;
    assign report.ry   = ry_reg;
    assign report.rz   = rz_reg;
    assign report.mask = held_reg;

endmodule

### rtl/mouse_event_buffer.sv
// Top level of the mouse event buffer: command sequencer and response register.
//
//   channel | dir | payload
//   cmd     | in  | func, delta_x, delta_y, wheel_steps, button_index, button_down, drain_max
//   rsp     | out | result_kind, report_dx/dy/dz, button_mask, event_code, event_value, last
//
// Each command is accepted in S_IDLE and run in S_EXEC; motion goes on to S_PUSH_Y,
// a state read to S_REPORT, an empty drain to S_EMPTY. Each drained event is a ring RAM
// read and a load of the response register, one RAM read port serving all of them.
// Reset clears accumulators, button mask and ring pointers at once; no clearing pass.
// A stalled rsp holds the sequencer before the next response load; commands that
// produce no response still complete while a response waits.
module mouse_event_buffer (
    input  logic        clk,
    input  logic        rst_n,
    mevb_cmd_if.sink    cmd,
    mevb_rsp_if.source  rsp
);
    import mevb_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_PUSH_Y = 7'b0000100,
        S_REPORT = 7'b0001000,
        S_EMPTY  = 7'b0010000,
        S_DRD    = 7'b0100000,
        S_DWAIT  = 7'b1000000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [RES_W-1:0]          remaining_reg;
    logic [RES_W-1:0]          remaining_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    rsp_t                      out_reg;
    rsp_t                      out_next;

    logic [FUNC_W-1:0]         func_reg;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic [IDX_W-1:0]          bidx_reg;
    logic                      down_reg;
    logic [DRAIN_W-1:0]        dmax_reg;

    logic                      accept;
    logic                      out_free;
    logic [CMP_W-1:0]          cnt_c;
    logic [CMP_W-1:0]          max_c;
    logic [CMP_W-1:0]          n_c;

    acc_cmd_t                  acc_cmd;
    acc_report_t               acc_rep;
    ring_cmd_t                 ring_cmd;
    ring_stat_t                ring_stat;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign cnt_c = CMP_W'(ring_stat.count);
    assign max_c = CMP_W'(dmax_reg);

    always_comb
    begin
        n_c = (cnt_c < max_c) ? cnt_c : max_c;
        if (n_c > CMP_W'(MAX_RESULTS))
            n_c = CMP_W'(MAX_RESULTS);
    end

    // Latch the command; form the wheel product here.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= cmd.func;
            dx_reg   <= cmd.delta_x;
            dy_reg   <= cmd.delta_y;
            z_reg    <= Z_W'(cmd.wheel_steps) * WHEEL_UNITS;
            bidx_reg <= cmd.button_index;
            down_reg <= cmd.button_down;
            dmax_reg <= cmd.drain_max;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        remaining_next = remaining_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;

        acc_cmd.op     = ACC_NONE;
        acc_cmd.dx     = dx_reg;
        acc_cmd.dy     = dy_reg;
        acc_cmd.z      = z_reg;
        acc_cmd.bidx   = bidx_reg;
        acc_cmd.down   = down_reg;

        ring_cmd.push        = 1'b0;
        ring_cmd.entry.code  = EV_X;
        ring_cmd.entry.value = whole32(ACC_W'(dx_reg));
        ring_cmd.pop_rd      = 1'b0;
        ring_cmd.pop_adv     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (func_reg)
                    FN_MOTION:
                    begin
                        acc_cmd.op    = ACC_MOTION;
                        ring_cmd.push = (dx_reg != '0);
                        state_next    = S_PUSH_Y;
                    end
                    FN_BUTTON:
                    begin
                        if (bidx_reg <= BTN_LAST)
                        begin
                            acc_cmd.op           = ACC_BUTTON;
                            ring_cmd.push        = 1'b1;
                            ring_cmd.entry.code  = EV_BTN0 + CODE_W'(bidx_reg);
                            ring_cmd.entry.value = down_reg ? PRESS_VALUE : '0;
                        end
                    end
                    FN_WHEEL:
                    begin
                        acc_cmd.op           = ACC_WHEEL;
                        ring_cmd.push        = 1'b1;
                        ring_cmd.entry.code  = EV_WHEEL;
                        ring_cmd.entry.value = whole32(ACC_W'(z_reg));
                    end
                    FN_READ:
                    begin
                        acc_cmd.op = ACC_CALC;
                        state_next = S_REPORT;
                    end
                    FN_DRAIN:
                    begin
                        remaining_next = RES_W'(n_c);
                        state_next     = (n_c == '0) ? S_EMPTY : S_DRD;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_PUSH_Y:
            begin
                ring_cmd.push        = (dy_reg != '0);
                ring_cmd.entry.code  = EV_Y;
                ring_cmd.entry.value = whole32(ACC_W'(dy_reg));
                state_next           = S_IDLE;
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    acc_cmd.op     = ACC_TAKE;
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.kind  = KIND_REPORT;
                    out_next.dx    = acc_rep.rx;
                    out_next.dy    = acc_rep.ry;
                    out_next.dz    = acc_rep.rz;
                    out_next.mask  = acc_rep.mask;
                    out_next.last  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.kind  = KIND_EMPTY;
                    out_next.last  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DRD:
            begin
                ring_cmd.pop_rd = 1'b1;
                state_next      = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (out_free)
                begin
                    ring_cmd.pop_adv = 1'b1;
                    out_valid_next   = 1'b1;
                    out_next         = '0;
                    out_next.kind    = KIND_EVENT;
                    out_next.code    = ring_stat.rdata.code;
                    out_next.value   = ring_stat.rdata.value;
                    out_next.last    = (remaining_reg == RES_W'(1));
                    remaining_next   = remaining_reg - RES_W'(1);
                    state_next       = (remaining_reg == RES_W'(1)) ? S_IDLE : S_DRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    mevb_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (acc_cmd),
        .report (acc_rep)
    );

    mevb_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ring_cmd),
        .stat  (ring_stat)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_kind = out_reg.kind;
    assign rsp.report_dx   = out_reg.dx;
    assign rsp.report_dy   = out_reg.dy;
    assign rsp.report_dz   = out_reg.dz;
    assign rsp.button_mask = out_reg.mask;
    assign rsp.event_code  = out_reg.code;
    assign rsp.event_value = out_reg.value;
    assign rsp.last        = out_reg.last;

    a_drain_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DWAIT |-> remaining_reg != '0)
        else $error("drain wait with nothing left");

    a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DWAIT && out_free && remaining_reg == RES_W'(1))
        |=> rsp.valid && rsp.last)
        else $error("final drained event not marked last");

    a_report_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT && out_free)
        |=> rsp.valid && rsp.result_kind == KIND_REPORT && rsp.event_value == '0)
        else $error("state report not loaded");

endmodule
